FILE: rtl/kms_pkg.sv
// kms_pkg: shared constants for the key matrix scan and debounce block.
// No dependencies; imported by every module of the block.
package kms_pkg;

  // default matrix shape
  localparam int unsigned ROWS_DEF = 6;
  localparam int unsigned COLS_DEF = 19;

  // fixed field widths
  localparam int unsigned COL_W   = 5;
  localparam int unsigned QCNT_W  = 8;
  localparam int unsigned PCNT_W  = 7;

  localparam logic [QCNT_W-1:0] RELOAD_RST = 8'd255;
  localparam logic [QCNT_W-1:0] RELOAD_MIN = 8'd1;
  localparam logic [PCNT_W-1:0] PCNT_MAX   = 7'd127;

  // status produced by the update logic for one request
  typedef struct packed {
    logic settled;
    logic bounce_seen;
  } kms_status_t;

endpackage

FILE: rtl/kms_in_reg.sv
// kms_in_reg: input register stage for scanned column requests.
// Depends on kms_pkg.
module kms_in_reg import kms_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [COL_W-1:0] in_column_index,
  input  logic [ROWS-1:0]  in_row_bits,
  input  logic             in_scan_end,
  input  logic             advance,
  output logic             st_valid,
  output logic [COL_W-1:0] st_column_index,
  output logic [ROWS-1:0]  st_row_bits,
  output logic             st_scan_end
);

  logic             valid_r, valid_nxt;
  logic [COL_W-1:0] col_r;
  logic [ROWS-1:0]  rows_r;
  logic             end_r;

  assign in_stall = valid_r && !advance;

  always_comb begin
    if (!in_stall) begin
      valid_nxt = in_valid;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      col_r  <= in_column_index;
      rows_r <= in_row_bits;
      end_r  <= in_scan_end;
    end
  end

  assign st_valid        = valid_r;
  assign st_column_index = col_r;
  assign st_row_bits     = rows_r;
  assign st_scan_end     = end_r;

endmodule

FILE: rtl/kms_core.sv
// kms_core: raw and stable matrices, shared quiet counter, key counts and
// the result register. Depends on kms_pkg.
module kms_core import kms_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [QCNT_W-1:0] cfg_data,
  input  logic              st_valid,
  input  logic [COL_W-1:0]  st_column_index,
  input  logic [ROWS-1:0]   st_row_bits,
  input  logic              st_scan_end,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROWS-1:0]   out_stable_column,
  output logic              out_settled,
  output logic              out_bounce_seen,
  output logic [PCNT_W-1:0] out_pressed_count
);

  localparam int unsigned IDX_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned KEYS   = ROWS * COLS;
  localparam int unsigned KCNT_W = $clog2(KEYS + 1);
  localparam int unsigned RCNT_W = $clog2(ROWS + 1);

  logic [ROWS-1:0]   raw_r    [COLS];
  logic [ROWS-1:0]   stable_r [COLS];
  logic [QCNT_W-1:0] reload_r;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [KCNT_W-1:0] raw_cnt_r, raw_cnt_nxt;
  logic [KCNT_W-1:0] stab_cnt_r, stab_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ROWS-1:0]   col_out_r, col_out_nxt;
  kms_status_t       stat_r, stat_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;

  logic              fire;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic [ROWS-1:0]   raw_old;
  logic              changed;
  logic [QCNT_W-1:0] q_after_load;
  logic              do_copy;
  logic [RCNT_W-1:0] pc_old, pc_new;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = st_valid && advance;
  assign in_range = {{(32-COL_W){1'b0}}, st_column_index} < COLS;
  assign idx      = in_range ? st_column_index[IDX_W-1:0] : '0;
  assign raw_old  = raw_r[idx];
  assign changed  = in_range && (raw_old != st_row_bits);

  // popcounts of the old and new column, for the running raw key count
  always_comb begin
    pc_old = '0;
    pc_new = '0;
    for (int r = 0; r < ROWS; r++) begin
      pc_old = pc_old + RCNT_W'(raw_old[r]);
      pc_new = pc_new + RCNT_W'(st_row_bits[r]);
    end
  end

  always_comb begin
    q_after_load = changed ? reload_r : qcnt_r;
    qcnt_nxt     = q_after_load;
    do_copy      = 1'b0;
    if (st_scan_end && (q_after_load != '0)) begin
      qcnt_nxt = q_after_load - 1'b1;
      do_copy  = (qcnt_nxt == '0);
    end
  end

  always_comb begin
    raw_cnt_nxt = raw_cnt_r;
    if (changed) begin
      raw_cnt_nxt = raw_cnt_r - KCNT_W'(pc_old) + KCNT_W'(pc_new);
    end
    stab_cnt_nxt = do_copy ? raw_cnt_nxt : stab_cnt_r;
  end

  // result fields
  always_comb begin
    if (!in_range) begin
      col_out_nxt = '0;
    end else if (do_copy) begin
      col_out_nxt = st_row_bits;   // raw column equals the input after update
    end else begin
      col_out_nxt = stable_r[idx];
    end
    stat_nxt.settled     = (qcnt_nxt == '0);
    stat_nxt.bounce_seen = changed && (qcnt_r != '0);
    if ({{(32-KCNT_W){1'b0}}, stab_cnt_nxt} > 32'(PCNT_MAX)) begin
      pcnt_nxt = PCNT_MAX;
    end else begin
      pcnt_nxt = PCNT_W'(stab_cnt_nxt);
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r    <= RELOAD_RST;
      qcnt_r      <= RELOAD_RST;
      raw_cnt_r   <= '0;
      stab_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < COLS; c++) begin
        raw_r[c]    <= '0;
        stable_r[c] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        reload_r <= (cfg_data == '0) ? RELOAD_MIN : cfg_data;
      end
      if (fire) begin
        qcnt_r     <= qcnt_nxt;
        raw_cnt_r  <= raw_cnt_nxt;
        stab_cnt_r <= stab_cnt_nxt;
        for (int c = 0; c < COLS; c++) begin
          if (changed && (idx == IDX_W'(c))) begin
            raw_r[c] <= st_row_bits;
          end
          if (do_copy) begin
            stable_r[c] <= (changed && (idx == IDX_W'(c))) ? st_row_bits : raw_r[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      col_out_r <= col_out_nxt;
      stat_r    <= stat_nxt;
      pcnt_r    <= pcnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stable_column = col_out_r;
  assign out_settled       = stat_r.settled;
  assign out_bounce_seen   = stat_r.bounce_seen;
  assign out_pressed_count = pcnt_r;

endmodule

FILE: rtl/key_matrix_scan_debounce_top.sv
// key_matrix_scan_debounce_top: top level of the key matrix scan debouncer.
// Depends on kms_pkg, kms_in_reg and kms_core.

// Takes one scanned column per request (index, active-high row bits, end of
// scan flag) and returns one result per request: the debounced bits of that
// column, a settled flag, a bounce flag and the number of keys pressed in
// the stable matrix. A shared quiet counter reloads from the cfg register
// (0 is taken as 1) on any change and counts down once per scan; at zero the
// raw matrix is copied to the stable matrix. One request is accepted every
// cycle while in_stall is low; a request passes through the input register
// and then the result register, where its result is held until taken. Reset
// clears both matrices.
module key_matrix_scan_debounce_top import kms_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [QCNT_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COL_W-1:0]  in_column_index,
  input  logic [ROWS-1:0]   in_row_bits,
  input  logic              in_scan_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROWS-1:0]   out_stable_column,
  output logic              out_settled,
  output logic              out_bounce_seen,
  output logic [PCNT_W-1:0] out_pressed_count
);

  logic             advance;
  logic             st_valid;
  logic [COL_W-1:0] st_column_index;
  logic [ROWS-1:0]  st_row_bits;
  logic             st_scan_end;

  assign cfg_ready = 1'b1;

  kms_in_reg #(
    .ROWS (ROWS)
  ) u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_column_index (in_column_index),
    .in_row_bits     (in_row_bits),
    .in_scan_end     (in_scan_end),
    .advance         (advance),
    .st_valid        (st_valid),
    .st_column_index (st_column_index),
    .st_row_bits     (st_row_bits),
    .st_scan_end     (st_scan_end)
  );

  kms_core #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .st_valid          (st_valid),
    .st_column_index   (st_column_index),
    .st_row_bits       (st_row_bits),
    .st_scan_end       (st_scan_end),
    .advance           (advance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stable_column (out_stable_column),
    .out_settled       (out_settled),
    .out_bounce_seen   (out_bounce_seen),
    .out_pressed_count (out_pressed_count)
  );

endmodule

FILE: test/debounce_checker.sv
// debounce_checker: watches the column, result and reload channels of the key
// matrix debouncer, predicts every result and compares it field by field.
// Depends on kms_pkg for widths and reset constants.
module debounce_checker import kms_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [QCNT_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [COL_W-1:0]  in_column_index,
  input  logic [ROWS-1:0]   in_row_bits,
  input  logic              in_scan_end,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ROWS-1:0]   out_stable_column,
  input  logic              out_settled,
  input  logic              out_bounce_seen,
  input  logic [PCNT_W-1:0] out_pressed_count,
  output int                mismatch_count,
  output int                columns_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 60;

  typedef struct packed {
    logic [ROWS-1:0]   stable_column;
    logic              settled;
    logic              bounce_seen;
    logic [PCNT_W-1:0] pressed_count;
  } column_result_t;

  logic [ROWS-1:0]   raw_keys    [COLS];
  logic [ROWS-1:0]   stable_keys [COLS];
  logic [QCNT_W-1:0] quiet_cnt;
  logic [QCNT_W-1:0] reload_val;
  column_result_t    expected_columns[$];
  int                results_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t ns: result %0d %0s: got %0d, want %0d",
               $realtime, results_seen, what, got, want);
    end
  endtask

  task automatic predict_scan_column(input logic [COL_W-1:0] col,
                                     input logic [ROWS-1:0] rows,
                                     input logic last);
    column_result_t res;
    logic           hit;
    int             total;
    res = '0;
    hit = (col < COLS);
    // compare and reload come before the end-of-scan countdown
    if (hit) begin
      if (raw_keys[col] != rows) begin
        raw_keys[col]   = rows;
        res.bounce_seen = (quiet_cnt != '0);
        quiet_cnt       = reload_val;
      end
    end
    if (last && quiet_cnt != '0) begin
      quiet_cnt = quiet_cnt - 1'b1;
      if (quiet_cnt == '0) stable_keys = raw_keys;
    end
    total = 0;
    for (int c = 0; c < COLS; c++) total += $countones(stable_keys[c]);
    if (total > PCNT_MAX) total = PCNT_MAX;
    res.stable_column = hit ? stable_keys[col] : '0;
    res.settled       = (quiet_cnt == '0);
    res.pressed_count = total[PCNT_W-1:0];
    expected_columns.push_back(res);
  endtask

  task automatic check_result();
    column_result_t want;
    if (expected_columns.size() == 0) begin
      report_mismatch("arrived with no request pending", 1, 0);
    end else begin
      want = expected_columns.pop_front();
      if (out_stable_column !== want.stable_column)
        report_mismatch("stable_column", out_stable_column, want.stable_column);
      if (out_settled !== want.settled)
        report_mismatch("settled", out_settled, want.settled);
      if (out_bounce_seen !== want.bounce_seen)
        report_mismatch("bounce_seen", out_bounce_seen, want.bounce_seen);
      if (out_pressed_count !== want.pressed_count)
        report_mismatch("pressed_count", out_pressed_count, want.pressed_count);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (raw_keys[c]) begin
        raw_keys[c]    = '0;
        stable_keys[c] = '0;
      end
      quiet_cnt      = RELOAD_RST;
      reload_val     = RELOAD_RST;
      mismatch_count = 0;
      results_seen   = 0;
      expected_columns.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      // a zero reload is taken as the minimum; the running count is left alone
      if (cfg_valid && cfg_ready) begin
        reload_val = (cfg_data == '0) ? RELOAD_MIN : cfg_data;
      end
      if (in_valid && !in_stall) begin
        predict_scan_column(in_column_index, in_row_bits, in_scan_end);
      end
    end
    columns_in_flight <= expected_columns.size();
  end

endmodule

FILE: test/testbench.sv
// testbench: drives scanned columns and reload writes into the key matrix
// debouncer with random gaps and stalls; debounce_checker does the checking.
// Depends on kms_pkg, key_matrix_scan_debounce_top and debounce_checker.
module testbench;
  import kms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS = ROWS_DEF;
  localparam int unsigned COLS = COLS_DEF;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int PHASE_ITEMS    = 90;
  localparam int QUIET_TAIL     = 256;
  localparam int HOLD_AT        = 250;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [QCNT_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [COL_W-1:0]  in_column_index = '0;
  logic [ROWS-1:0]   in_row_bits = '0;
  logic              in_scan_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ROWS-1:0]   out_stable_column;
  logic              out_settled;
  logic              out_bounce_seen;
  logic [PCNT_W-1:0] out_pressed_count;

  int                mismatch_count;
  int                columns_in_flight;
  int                idle_cycles = 0;
  bit                source_steady = 1'b0;
  logic [ROWS-1:0]   target_keys [COLS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  key_matrix_scan_debounce_top #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_column_index   (in_column_index),
    .in_row_bits       (in_row_bits),
    .in_scan_end       (in_scan_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stable_column (out_stable_column),
    .out_settled       (out_settled),
    .out_bounce_seen   (out_bounce_seen),
    .out_pressed_count (out_pressed_count)
  );

  debounce_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_column_index   (in_column_index),
    .in_row_bits       (in_row_bits),
    .in_scan_end       (in_scan_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stable_column (out_stable_column),
    .out_settled       (out_settled),
    .out_bounce_seen   (out_bounce_seen),
    .out_pressed_count (out_pressed_count),
    .mismatch_count    (mismatch_count),
    .columns_in_flight (columns_in_flight)
  );

  // watchdog on cycles where no channel moves a request
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_item(input logic [COL_W-1:0] col, input logic [ROWS-1:0] rows,
                           input logic last);
    int gap;
    gap = source_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_column_index <= col;
    in_row_bits     <= rows;
    in_scan_end     <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // reload is written only with nothing in flight
  task automatic write_reload(input logic [QCNT_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (columns_in_flight != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // mostly ordered scans of a slowly changing matrix, some with chatter or cut
  // short, mixed with bursts of random columns
  task automatic run_scans(input int n_items);
    int              sent;
    int              k;
    int              stop_col;
    logic [ROWS-1:0] rows;
    bit              bouncy;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 4);
        repeat (k) send_item(COL_W'($urandom_range(0, 31)), ROWS'($urandom), 1'($urandom));
        sent += k;
      end else begin
        case ($urandom_range(0, 5))
          0: foreach (target_keys[c]) target_keys[c] = ROWS'($urandom);
          1, 2: begin
            k = $urandom_range(0, COLS - 1);
            target_keys[k] = target_keys[k] ^ ROWS'(1 << $urandom_range(0, ROWS - 1));
          end
          default: ;
        endcase
        bouncy   = ($urandom_range(0, 3) == 0);
        stop_col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, COLS - 2) : COLS - 1;
        for (int c = 0; c <= stop_col; c++) begin
          rows = target_keys[c];
          if (bouncy && $urandom_range(0, 9) == 0) begin
            rows = rows ^ ROWS'(1 << $urandom_range(0, ROWS - 1));
          end
          send_item(COL_W'(c), rows, c == stop_col);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [QCNT_W-1:0] reload, input bit quiet_tail);
    write_reload(reload);
    source_steady = ($urandom_range(0, 2) == 0);
    run_scans(PHASE_ITEMS);
    // long run of end-of-scan marks on unused columns lets a big reload expire
    if (quiet_tail) begin
      repeat (QUIET_TAIL) send_item(COL_W'($urandom_range(COLS, 31)), ROWS'($urandom), 1'b1);
    end
  endtask

  initial begin : result_sink
    int stall_len;
    int taken;
    bit sink_steady;
    taken       = 0;
    sink_steady = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 100 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) stall_len = HOLD_CYCLES;
      else if (sink_steady) stall_len = 0;
      else stall_len = $urandom_range(0, 11);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  initial begin : stimulus
    foreach (target_keys[c]) target_keys[c] = ROWS'($urandom);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset reload still counting: every change is a bounce
    send_item(COL_W'(0), '1, 1'b0);
    send_item(COL_W'(COLS - 1), '1, 1'b0);
    send_item(COL_W'(COLS), ROWS'(6'h15), 1'b0);
    send_item('1, ROWS'(6'h2a), 1'b1);
    send_item(COL_W'(0), '1, 1'b1);
    send_item(COL_W'(7), '0, 1'b0);
    // zero reload is clamped; counter keeps its value until the next change
    write_reload('0);
    send_item(COL_W'(31), '0, 1'b1);
    send_item(COL_W'(5), ROWS'(6'h01), 1'b1);
    send_item(COL_W'(5), ROWS'(6'h01), 1'b1);
    send_item(COL_W'(5), ROWS'(6'h20), 1'b0);
    send_item(COL_W'(5), ROWS'(6'h20), 1'b1);
    send_item(COL_W'(12), '1, 1'b1);
    send_item(COL_W'(COLS - 1), '0, 1'b0);
    send_item(COL_W'(20), '1, 1'b1);

    run_phase(8'd1, 1'b0);
    run_phase(8'd2, 1'b0);
    run_phase(8'd255, 1'b1);
    run_phase(8'd3, 1'b0);
    run_phase(8'd0, 1'b0);
    run_phase(QCNT_W'($urandom_range(4, 8)), 1'b0);
    run_phase(QCNT_W'($urandom_range(0, 255)), 1'b0);
    run_phase(8'd1, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (columns_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && columns_in_flight == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
